### rtl/vrrs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package vrrs_pkg;

    localparam int DEPTH       = 1024;
    localparam int AW          = 10;
    localparam int CHUNK_BYTES = 8;
    localparam int LEAD_BYTES  = 1;
    localparam int TRAIL_BYTES = 1;

    typedef enum logic [1:0] {
        OP_ADD        = 2'd0,
        OP_TAKE_FIRST = 2'd1,
        OP_TAKE_LAST  = 2'd2,
        OP_PEEK       = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_EMPTY      = 3'd1,
        ST_NO_ROOM    = 3'd2,
        ST_BAD_LENGTH = 3'd3,
        ST_BAD_OFFSET = 3'd4,
        ST_TOO_LONG   = 3'd5
    } status_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_PEND_RD,
        S_PEND_WR,
        S_FIN,
        S_CHK,
        S_DROP_RD,
        S_DROP_UPD,
        S_LAST_RD,
        S_LAST_UPD,
        S_START,
        S_BYTE,
        S_EMIT,
        S_TK_RD,
        S_TK_LEN,
        S_PREV_RD,
        S_PREV_UPD,
        S_CH_INIT,
        S_CH_RD,
        S_CH_CAP,
        S_CH_EMIT
    } state_t;

endpackage
`default_nettype wire

### rtl/vrrs_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface vrrs_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] data_byte;
    logic [7:0] record_length;
    logic [9:0] offset;
    logic [7:0] accept_limit;

    modport source (output valid, operation, data_byte, record_length, offset, accept_limit,
                    input ready);
    modport sink   (input valid, operation, data_byte, record_length, offset, accept_limit,
                    output ready);
endinterface

interface vrrs_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic [7:0]         length_out;
    logic [63:0]        data;
    logic [3:0]         byte_count;
    logic               last;
    logic signed [10:0] next_offset;
    logic signed [10:0] prev_offset;
    logic [8:0]         records_held;
    logic [10:0]        free_bytes;

    modport source (output valid, status, length_out, data, byte_count, last, next_offset,
                    prev_offset, records_held, free_bytes, input ready);
    modport sink   (input valid, status, length_out, data, byte_count, last, next_offset,
                    prev_offset, records_held, free_bytes, output ready);
endinterface
`default_nettype wire

### rtl/variable_record_ring_store.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel  | Dir | Handshake     | Word
// in_ch    | in  | valid/ready   | operation, data_byte, record_length, offset, accept_limit
// out_ch   | out | valid/ready   | status .. free_bytes, one word per chunk, per add or per refused request
// cfg      | in  | cfg_we        | overwrite_oldest
//
// One word in flight at a time; everything goes through a 1024x8 store with one write port
// and a registered read port. When overwrite is on, add_byte drops the oldest records as
// needed to make room; take/peek return the record as one output word per chunk of up to
// 8 bytes.
// Output is one register; the sequencer stalls while it is full and not taken.
// Reset is async, active low; store contents are not cleared, no sweep after reset.
module variable_record_ring_store (
    input  wire logic  clk,
    input  wire logic  rst_n,
    vrrs_in_if.sink    in_ch,
    vrrs_out_if.source out_ch,
    input  wire logic  cfg_we,
    input  wire logic  overwrite_oldest
);

    localparam logic signed [10:0] NO_OFFSET = -11'sd1;
    localparam logic [10:0] DEPTH_W = 11'(vrrs_pkg::DEPTH);
    localparam logic [10:0] FRAME   = 11'(vrrs_pkg::LEAD_BYTES + vrrs_pkg::TRAIL_BYTES);
    localparam logic [3:0]  CB      = 4'(vrrs_pkg::CHUNK_BYTES);
    localparam int          AW      = vrrs_pkg::AW;

    vrrs_pkg::state_t state_reg, state_next;

    // latched request
    logic [1:0] op_reg;
    logic [7:0] byte_reg, rlen_reg, lim_reg;
    logic [9:0] off_reg;

    // ring bookkeeping
    logic [AW-1:0] first_reg, first_next, last_reg, last_next, wpos_reg, wpos_next;
    logic [10:0]   room_reg, room_next;
    logic [8:0]    total_reg, total_next;
    logic [7:0]    bt_reg, bt_next;
    logic [1:0]    pend_reg, pend_next;
    logic          ow_reg;

    // working registers
    logic [AW-1:0]      pos_reg, pos_next;
    logic [7:0]         len_reg, len_next, idx_reg, idx_next;
    logic [3:0]         j_reg, j_next, cnt_reg, cnt_next;
    logic [63:0]        chunk_reg, chunk_next;
    logic [2:0]         res_st_reg, res_st_next;
    logic [7:0]         res_len_reg, res_len_next;
    logic signed [10:0] nxt_reg, nxt_next, prv_reg, prv_next;

    // output register
    logic               ov_reg;
    logic [2:0]         o_st_reg;
    logic [7:0]         o_len_reg;
    logic [63:0]        o_data_reg;
    logic [3:0]         o_cnt_reg;
    logic               o_last_reg;
    logic signed [10:0] o_nxt_reg, o_prv_reg;
    logic [8:0]         o_held_reg;
    logic [10:0]        o_free_reg;

    // store
    logic [7:0]    mem [vrrs_pkg::DEPTH];
    logic [7:0]    rd_data_reg;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [7:0]    wr_data;
    logic          wr_en;

    logic          accept, slot_free, load_single, load_chunk;
    logic [10:0]   need;
    logic          room_short;
    logic [AW-1:0] hop;
    logic [7:0]    bt_inc;
    logic [11:0]   room_back;
    logic [10:0]   room_ret;
    logic [7:0]    idx_sum;
    logic [7:0]    rem;
    logic          chunk_last;

    assign accept      = in_ch.valid & in_ch.ready;
    assign in_ch.ready = (state_reg == vrrs_pkg::S_IDLE);
    assign slot_free   = ~ov_reg | out_ch.ready;

    assign need       = {3'b0, rlen_reg} + FRAME;
    assign room_short = room_reg < need;
    assign hop        = AW'({3'b0, rd_data_reg} + FRAME);
    assign bt_inc     = (bt_reg == 8'hFF) ? bt_reg : bt_reg + 8'd1;
    // give_back uses the length byte read at the record being removed
    assign room_back  = {1'b0, room_reg} + {4'b0, rd_data_reg} + {1'b0, FRAME};
    assign room_ret   = (room_back > {1'b0, DEPTH_W}) ? DEPTH_W : room_back[10:0];
    assign idx_sum    = idx_reg + {4'b0, cnt_reg};
    assign rem        = len_reg - idx_sum;
    assign chunk_last = idx_sum >= len_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            vrrs_pkg::S_IDLE:
                if (accept) state_next = vrrs_pkg::S_DISPATCH;
            vrrs_pkg::S_DISPATCH:
                if (op_reg == vrrs_pkg::OP_ADD)
                begin
                    if (pend_reg[0])              state_next = vrrs_pkg::S_PEND_RD;
                    else if (pend_reg[1])         state_next = vrrs_pkg::S_EMIT;
                    else if (rlen_reg == 8'd0)    state_next = vrrs_pkg::S_EMIT;
                    else                          state_next = vrrs_pkg::S_CHK;
                end
                else if (op_reg == vrrs_pkg::OP_PEEK && {1'b0, off_reg} >= DEPTH_W)
                    state_next = vrrs_pkg::S_EMIT;
                else if (total_reg == 9'd0)
                    state_next = vrrs_pkg::S_EMIT;
                else
                    state_next = vrrs_pkg::S_TK_RD;
            vrrs_pkg::S_PEND_RD:  state_next = vrrs_pkg::S_PEND_WR;
            vrrs_pkg::S_PEND_WR:
                state_next = (bt_inc >= rd_data_reg) ? vrrs_pkg::S_FIN : vrrs_pkg::S_EMIT;
            vrrs_pkg::S_FIN:      state_next = vrrs_pkg::S_EMIT;
            vrrs_pkg::S_CHK:
                if (ow_reg && room_short && total_reg != 9'd0)
                    state_next = vrrs_pkg::S_DROP_RD;
                else if (room_short)
                    state_next = vrrs_pkg::S_EMIT;
                else if (total_reg != 9'd0)
                    state_next = vrrs_pkg::S_LAST_RD;
                else
                    state_next = vrrs_pkg::S_START;
            vrrs_pkg::S_DROP_RD:  state_next = vrrs_pkg::S_DROP_UPD;
            vrrs_pkg::S_DROP_UPD: state_next = vrrs_pkg::S_CHK;
            vrrs_pkg::S_LAST_RD:  state_next = vrrs_pkg::S_LAST_UPD;
            vrrs_pkg::S_LAST_UPD: state_next = vrrs_pkg::S_START;
            vrrs_pkg::S_START:    state_next = vrrs_pkg::S_BYTE;
            vrrs_pkg::S_BYTE:
                state_next = (rlen_reg == 8'd1) ? vrrs_pkg::S_FIN : vrrs_pkg::S_EMIT;
            vrrs_pkg::S_EMIT:
                if (slot_free) state_next = vrrs_pkg::S_IDLE;
            vrrs_pkg::S_TK_RD:    state_next = vrrs_pkg::S_TK_LEN;
            vrrs_pkg::S_TK_LEN:
                if (rd_data_reg > lim_reg)
                    state_next = vrrs_pkg::S_EMIT;
                else if (op_reg == vrrs_pkg::OP_PEEK && pos_reg != first_reg)
                    state_next = vrrs_pkg::S_PREV_RD;
                else if (op_reg == vrrs_pkg::OP_TAKE_LAST && rd_data_reg != 8'd0)
                    state_next = vrrs_pkg::S_PREV_RD;
                else
                    state_next = vrrs_pkg::S_CH_INIT;
            vrrs_pkg::S_PREV_RD:  state_next = vrrs_pkg::S_PREV_UPD;
            vrrs_pkg::S_PREV_UPD: state_next = vrrs_pkg::S_CH_INIT;
            vrrs_pkg::S_CH_INIT:  state_next = vrrs_pkg::S_CH_RD;
            vrrs_pkg::S_CH_RD:
                state_next = (j_reg == cnt_reg) ? vrrs_pkg::S_CH_EMIT : vrrs_pkg::S_CH_CAP;
            vrrs_pkg::S_CH_CAP:   state_next = vrrs_pkg::S_CH_RD;
            vrrs_pkg::S_CH_EMIT:
                if (slot_free)
                    state_next = chunk_last ? vrrs_pkg::S_IDLE : vrrs_pkg::S_CH_RD;
            default:              state_next = vrrs_pkg::S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        first_next   = first_reg;
        last_next    = last_reg;
        wpos_next    = wpos_reg;
        room_next    = room_reg;
        total_next   = total_reg;
        bt_next      = bt_reg;
        pend_next    = pend_reg;
        pos_next     = pos_reg;
        len_next     = len_reg;
        idx_next     = idx_reg;
        j_next       = j_reg;
        cnt_next     = cnt_reg;
        chunk_next   = chunk_reg;
        res_st_next  = res_st_reg;
        res_len_next = res_len_reg;
        nxt_next     = nxt_reg;
        prv_next     = prv_reg;
        rd_addr      = pos_reg;
        wr_addr      = wpos_reg;
        wr_data      = byte_reg;
        wr_en        = 1'b0;
        load_single  = 1'b0;
        load_chunk   = 1'b0;
        unique case (state_reg)
            vrrs_pkg::S_DISPATCH:
            begin
                nxt_next = NO_OFFSET;
                prv_next = NO_OFFSET;
                if (op_reg == vrrs_pkg::OP_ADD)
                begin
                    if (pend_reg[0])
                    begin
                        pos_next = wpos_reg;
                    end
                    else if (pend_reg[1])
                    begin
                        // skipping a refused record
                        bt_next = bt_inc;
                        if (bt_inc >= rlen_reg)
                        begin
                            pend_next = 2'b00;
                            bt_next   = 8'd0;
                        end
                        res_st_next  = vrrs_pkg::ST_NO_ROOM;
                        res_len_next = rlen_reg;
                    end
                    else if (rlen_reg == 8'd0)
                    begin
                        res_st_next  = vrrs_pkg::ST_BAD_LENGTH;
                        res_len_next = 8'd0;
                    end
                end
                else
                begin
                    pend_next    = 2'b00;
                    bt_next      = 8'd0;
                    res_len_next = 8'd0;
                    pos_next     = (op_reg == vrrs_pkg::OP_PEEK) ? AW'(off_reg) :
                                   (op_reg == vrrs_pkg::OP_TAKE_FIRST) ? first_reg : last_reg;
                    if (op_reg == vrrs_pkg::OP_PEEK && {1'b0, off_reg} >= DEPTH_W)
                        res_st_next = vrrs_pkg::ST_BAD_OFFSET;
                    else
                        res_st_next = vrrs_pkg::ST_EMPTY;
                end
            end
            vrrs_pkg::S_PEND_RD:
            begin
                // leading length byte of the open record
                rd_addr  = wpos_reg - AW'({2'b0, bt_reg} + 10'd1);
                pos_next = rd_addr;
            end
            vrrs_pkg::S_PEND_WR:
            begin
                wr_en        = 1'b1;
                wr_addr      = wpos_reg;
                wr_data      = byte_reg;
                wpos_next    = wpos_reg + AW'(1);
                bt_next      = bt_inc;
                len_next     = rd_data_reg;
                res_st_next  = vrrs_pkg::ST_OK;
                res_len_next = rd_data_reg;
            end
            vrrs_pkg::S_FIN:
            begin
                wr_en      = 1'b1;
                wr_addr    = wpos_reg;
                wr_data    = len_reg;
                wpos_next  = wpos_reg + AW'(1);
                room_next  = (room_reg >= {3'b0, len_reg} + FRAME) ?
                             room_reg - ({3'b0, len_reg} + FRAME) : 11'd0;
                if (total_reg == 9'd0) first_next = pos_reg;
                last_next  = pos_reg;
                total_next = total_reg + 9'd1;
                pend_next  = 2'b00;
                bt_next    = 8'd0;
            end
            vrrs_pkg::S_CHK:
            begin
                if (!(ow_reg && room_short && total_reg != 9'd0) && room_short)
                begin
                    if (rlen_reg > 8'd1)
                    begin
                        pend_next = 2'b10;
                        bt_next   = 8'd1;
                    end
                    res_st_next  = vrrs_pkg::ST_NO_ROOM;
                    res_len_next = rlen_reg;
                end
                pos_next = first_reg;
            end
            vrrs_pkg::S_DROP_RD:
                rd_addr = first_reg;
            vrrs_pkg::S_DROP_UPD:
            begin
                room_next  = room_ret;
                total_next = total_reg - 9'd1;
                first_next = first_reg + hop;
            end
            vrrs_pkg::S_LAST_RD:
                rd_addr = last_reg;
            vrrs_pkg::S_LAST_UPD:
                pos_next = last_reg + hop;
            vrrs_pkg::S_START:
            begin
                wr_en    = 1'b1;
                wr_addr  = pos_reg;
                wr_data  = rlen_reg;
                len_next = rlen_reg;
            end
            vrrs_pkg::S_BYTE:
            begin
                wr_en        = 1'b1;
                wr_addr      = pos_reg + AW'(1);
                wr_data      = byte_reg;
                wpos_next    = pos_reg + AW'(2);
                bt_next      = 8'd1;
                res_st_next  = vrrs_pkg::ST_OK;
                res_len_next = rlen_reg;
                if (rlen_reg != 8'd1) pend_next = 2'b01;
            end
            vrrs_pkg::S_EMIT:
                load_single = slot_free;
            vrrs_pkg::S_TK_RD:
                rd_addr = pos_reg;
            vrrs_pkg::S_TK_LEN:
            begin
                len_next = rd_data_reg;
                if (rd_data_reg > lim_reg)
                begin
                    res_st_next  = vrrs_pkg::ST_TOO_LONG;
                    res_len_next = rd_data_reg;
                end
                else if (op_reg == vrrs_pkg::OP_PEEK)
                begin
                    if (pos_reg != last_reg)
                        nxt_next = $signed({1'b0, pos_reg + hop});
                end
                else if (rd_data_reg != 8'd0)
                begin
                    room_next  = room_ret;
                    total_next = total_reg - 9'd1;
                    if (op_reg == vrrs_pkg::OP_TAKE_FIRST)
                        first_next = first_reg + hop;
                end
            end
            vrrs_pkg::S_PREV_RD:
                rd_addr = pos_reg - AW'(1);
            vrrs_pkg::S_PREV_UPD:
            begin
                // trailing length byte sits just before pos
                if (op_reg == vrrs_pkg::OP_PEEK)
                    prv_next = $signed({1'b0, pos_reg - AW'(1) - hop + AW'(1)});
                else
                    last_next = pos_reg - AW'(1) - hop + AW'(1);
            end
            vrrs_pkg::S_CH_INIT:
            begin
                idx_next   = 8'd0;
                j_next     = 4'd0;
                chunk_next = 64'd0;
                cnt_next   = (len_reg >= {4'b0, CB}) ? CB : len_reg[3:0];
            end
            vrrs_pkg::S_CH_RD:
                rd_addr = pos_reg + AW'(1) + AW'(idx_reg) + AW'(j_reg);
            vrrs_pkg::S_CH_CAP:
            begin
                for (int k = 0; k < vrrs_pkg::CHUNK_BYTES; k++)
                begin
                    if (j_reg == 4'(k)) chunk_next[8*k +: 8] = rd_data_reg;
                end
                j_next = j_reg + 4'd1;
            end
            vrrs_pkg::S_CH_EMIT:
            begin
                load_chunk = slot_free;
                if (slot_free)
                begin
                    idx_next   = idx_sum;
                    j_next     = 4'd0;
                    chunk_next = 64'd0;
                    cnt_next   = (rem >= {4'b0, CB}) ? CB : rem[3:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= vrrs_pkg::S_IDLE;
            first_reg <= '0;
            last_reg  <= '0;
            wpos_reg  <= '0;
            room_reg  <= DEPTH_W;
            total_reg <= 9'd0;
            bt_reg    <= 8'd0;
            pend_reg  <= 2'b00;
            ow_reg    <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            first_reg <= first_next;
            last_reg  <= last_next;
            wpos_reg  <= wpos_next;
            room_reg  <= room_next;
            total_reg <= total_next;
            bt_reg    <= bt_next;
            pend_reg  <= pend_next;
            if (cfg_we) ow_reg <= overwrite_oldest;
            if (load_single || load_chunk) ov_reg <= 1'b1;
            else if (out_ch.ready)         ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= in_ch.operation;
            byte_reg <= in_ch.data_byte;
            rlen_reg <= in_ch.record_length;
            off_reg  <= in_ch.offset;
            lim_reg  <= in_ch.accept_limit;
        end
        pos_reg     <= pos_next;
        len_reg     <= len_next;
        idx_reg     <= idx_next;
        j_reg       <= j_next;
        cnt_reg     <= cnt_next;
        chunk_reg   <= chunk_next;
        res_st_reg  <= res_st_next;
        res_len_reg <= res_len_next;
        nxt_reg     <= nxt_next;
        prv_reg     <= prv_next;
        if (load_single)
        begin
            o_st_reg   <= res_st_reg;
            o_len_reg  <= res_len_reg;
            o_data_reg <= 64'd0;
            o_cnt_reg  <= 4'd0;
            o_last_reg <= 1'b1;
            o_nxt_reg  <= NO_OFFSET;
            o_prv_reg  <= NO_OFFSET;
            o_held_reg <= total_reg;
            o_free_reg <= room_reg;
        end
        else if (load_chunk)
        begin
            o_st_reg   <= vrrs_pkg::ST_OK;
            o_len_reg  <= len_reg;
            o_data_reg <= chunk_reg;
            o_cnt_reg  <= cnt_reg;
            o_last_reg <= chunk_last;
            o_nxt_reg  <= nxt_reg;
            o_prv_reg  <= prv_reg;
            o_held_reg <= total_reg;
            o_free_reg <= room_reg;
        end
    end

    assign out_ch.valid        = ov_reg;
    assign out_ch.status       = o_st_reg;
    assign out_ch.length_out   = o_len_reg;
    assign out_ch.data         = o_data_reg;
    assign out_ch.byte_count   = o_cnt_reg;
    assign out_ch.last         = o_last_reg;
    assign out_ch.next_offset  = o_nxt_reg;
    assign out_ch.prev_offset  = o_prv_reg;
    assign out_ch.records_held = o_held_reg;
    assign out_ch.free_bytes   = o_free_reg;

endmodule
`default_nettype wire

### rtl/vrrs_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module vrrs_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [2:0] out_status,
    input wire logic [3:0] out_count,
    input wire logic       out_last
);

    // a stalled word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_count))
        else $error("output word changed while stalled");

    // busy right after taking a word
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready one cycle after accept");

    // error words are single and empty
    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_status != vrrs_pkg::ST_OK |-> out_last && out_count == 4'd0)
        else $error("error word with data or not last");

    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_count <= 4'(vrrs_pkg::CHUNK_BYTES))
        else $error("byte_count beyond chunk size");

endmodule

bind variable_record_ring_store vrrs_checker u_vrrs_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_status (out_ch.status),
    .out_count  (out_ch.byte_count),
    .out_last   (out_ch.last)
);
`default_nettype wire
